[rtl/core/dstof_pkg.sv]
// dstof_pkg: widths and stage types for the two-way ranging time-of-flight pipeline
// no dependencies
package dstof_pkg;

    localparam int TS_W   = 32;
    localparam int PROD_W = 64;
    localparam int DEN_W  = 34;
    localparam int OUT_W  = 33;

    // quotient bits: magnitude stays below 2^32
    localparam int Q_W    = 32;
    localparam int QIDX_W = 5;

    // divider stage: partial remainder, quotient built so far, sign, flag
    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] num;
        logic [DEN_W-1:0]  den;
        logic [DEN_W:0]    rem;
        logic [Q_W-1:0]    quot;
        logic              neg;
        logic              zero;
    } div_stage_t;

endpackage

[rtl/core/ds_twr_time_of_flight.sv]
// ds_twr_time_of_flight: pipelined asymmetric double-sided two-way ranging time of flight
// depends on dstof_pkg
//
// one request per clock cycle: busy is never raised, so start is taken at every edge.
// each request gives one result, marked by done for one cycle; the
// receiver cannot stall, so the pipeline never holds. stages: interval subtraction,
// 32x32 products and interval sum, numerator magnitude and sign, then 32 restoring
// division stages (one quotient bit each, high bit first), then sign fix-up.
// latency is set by the one-bit-per-stage divider chain.
module ds_twr_time_of_flight (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dstof_pkg::TS_W-1:0]   local_poll_rx,
    input  logic [dstof_pkg::TS_W-1:0]   local_resp_tx,
    input  logic [dstof_pkg::TS_W-1:0]   local_final_rx,
    input  logic [dstof_pkg::TS_W-1:0]   remote_poll_tx,
    input  logic [dstof_pkg::TS_W-1:0]   remote_resp_rx,
    input  logic [dstof_pkg::TS_W-1:0]   remote_final_tx,
    output logic                         done,
    output logic signed [dstof_pkg::OUT_W-1:0] flight_time,
    output logic                         zero_divisor
);

    localparam int TW = dstof_pkg::TS_W;
    localparam int PW = dstof_pkg::PROD_W;
    localparam int DW = dstof_pkg::DEN_W;
    localparam int QW = dstof_pkg::Q_W;

    assign busy = 1'b0;

    // stage 1: four intervals, modulo 2^32
    logic          s1_valid_reg;
    logic [TW-1:0] ra_reg, rb_reg, da_reg, db_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ra_reg <= remote_resp_rx - remote_poll_tx;
        rb_reg <= local_final_rx - local_resp_tx;
        da_reg <= remote_final_tx - remote_resp_rx;
        db_reg <= local_resp_tx - local_poll_rx;
    end

    // stage 2: two products and the divisor
    logic          s2_valid_reg;
    logic [PW-1:0] p_reg, q_reg;
    logic [DW-1:0] den2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= PW'(ra_reg) * PW'(rb_reg);
        q_reg    <= PW'(da_reg) * PW'(db_reg);
        den2_reg <= DW'(ra_reg) + DW'(rb_reg) + DW'(da_reg) + DW'(db_reg);
    end

    // stage 3: numerator magnitude and sign, seeds the divider
    dstof_pkg::div_stage_t stg_reg [QW+1];
    dstof_pkg::div_stage_t stg_next [QW+1];

    always_comb
    begin
        stg_next[0]       = '0;
        stg_next[0].valid = s2_valid_reg;
        stg_next[0].den   = den2_reg;
        stg_next[0].zero  = (den2_reg == '0);
        if (p_reg >= q_reg)
        begin
            stg_next[0].num = p_reg - q_reg;
            stg_next[0].neg = 1'b0;
        end
        else
        begin
            stg_next[0].num = q_reg - p_reg;
            stg_next[0].neg = 1'b1;
        end
        // quotient < 2^32, so the top 32 bits of the numerator seed the remainder
        stg_next[0].rem = (DW+1)'(stg_next[0].num[PW-1:QW]);
    end

    // divider stages: one quotient bit each; a zero divisor leaves quotient zero
    for (genvar i = 1; i <= QW; i++)
    begin : g_div
        logic [DW+1:0] shifted;
        logic [DW+1:0] diff;
        always_comb
        begin
            stg_next[i] = stg_reg[i-1];
            shifted = {stg_reg[i-1].rem, stg_reg[i-1].num[QW-i]};
            diff    = shifted - (DW+2)'(stg_reg[i-1].den);
            if (!diff[DW+1] && !stg_reg[i-1].zero)
            begin
                stg_next[i].rem  = diff[DW:0];
                stg_next[i].quot = {stg_reg[i-1].quot[QW-2:0], 1'b1};
            end
            else
            begin
                stg_next[i].rem  = shifted[DW:0];
                stg_next[i].quot = {stg_reg[i-1].quot[QW-2:0], 1'b0};
            end
        end
    end

    for (genvar i = 0; i <= QW; i++)
    begin : g_stg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stg_reg[i] <= '0;
            else
                stg_reg[i] <= stg_next[i];
        end
    end

    // output stage: apply sign
    logic done_reg;
    logic [dstof_pkg::OUT_W-1:0] flight_reg;
    logic zero_reg;
    logic [dstof_pkg::OUT_W-1:0] mag_ext;

    assign mag_ext = {1'b0, stg_reg[QW].quot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stg_reg[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        flight_reg <= stg_reg[QW].neg ? (~mag_ext + 1'b1) : mag_ext;
        zero_reg   <= stg_reg[QW].zero;
    end

    assign done         = done_reg;
    assign flight_time  = flight_reg;
    assign zero_divisor = zero_reg;

endmodule

[rtl/core/dstof_checker.sv]
// dstof_checker: port-level checks for ds_twr_time_of_flight, with bind
// depends on dstof_pkg
module dstof_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [dstof_pkg::OUT_W-1:0]  flight_time,
    input logic                         zero_divisor
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_divisor) |-> (flight_time == '0))
        else $error("zero divisor with nonzero result");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##36 done)
        else $error("result missing after request");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 36))
        else $error("result without request");

endmodule

bind ds_twr_time_of_flight dstof_checker u_dstof_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .flight_time(flight_time), .zero_divisor(zero_divisor)
);

[verif/ds_twr_time_of_flight_test.sv]
// testbench for ds_twr_time_of_flight: random and directed ranging exchanges,
// results checked in order against an exact integer time-of-flight predictor
// depends on dstof_pkg and the ds_twr_time_of_flight rtl
module ds_twr_time_of_flight_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TS_W   = dstof_pkg::TS_W;
    localparam int OUT_W  = dstof_pkg::OUT_W;
    localparam int DEN_W  = dstof_pkg::DEN_W;
    localparam int PROD_W = dstof_pkg::PROD_W;

    // one ranging exchange and its expected outcome
    typedef struct {
        logic [TS_W-1:0] l_poll_rx;
        logic [TS_W-1:0] l_resp_tx;
        logic [TS_W-1:0] l_final_rx;
        logic [TS_W-1:0] r_poll_tx;
        logic [TS_W-1:0] r_resp_rx;
        logic [TS_W-1:0] r_final_tx;
    } exchange_t;

    typedef struct {
        logic [OUT_W-1:0] tof;
        logic             zero_div;
    } tof_result_t;

    // scoreboard: predicts the flight time of each accepted request and checks results
    class tof_scoreboard;
        tof_result_t pending[$];
        int          mismatches;
        int          checked;

        function tof_result_t predict_tof(exchange_t x);
            logic [TS_W-1:0] ra, rb, da, db;
            logic [DEN_W-1:0] den;
            logic [PROD_W-1:0] p, q, mag, quo;
            tof_result_t r;
            ra = x.r_resp_rx - x.r_poll_tx;
            rb = x.l_final_rx - x.l_resp_tx;
            da = x.r_final_tx - x.r_resp_rx;
            db = x.l_resp_tx - x.l_poll_rx;
            den = DEN_W'(ra) + DEN_W'(rb) + DEN_W'(da) + DEN_W'(db);
            p = PROD_W'(ra) * PROD_W'(rb);
            q = PROD_W'(da) * PROD_W'(db);
            if (den == 0)
            begin
                r.tof = '0;
                r.zero_div = 1'b1;
                return r;
            end
            mag = (p >= q) ? p - q : q - p;
            quo = mag / PROD_W'(den);
            if (p < q)
                quo = -quo;
            r.tof = quo[OUT_W-1:0];
            r.zero_div = 1'b0;
            return r;
        endfunction

        function void note_request(exchange_t x);
            pending.push_back(predict_tof(x));
        endfunction

        function void check_result(logic [OUT_W-1:0] tof, logic zd);
            tof_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tof=%h zero_divisor=%b", tof, zd);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.tof !== tof || e.zero_div !== zd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected tof=%h zd=%b, got tof=%h zd=%b",
                             e.tof, e.zero_div, tof, zd);
            end
        endfunction
    endclass

    localparam int IDLE_PCT     = 22;
    localparam int RANDOM_COUNT = 1700;
    localparam int DRAIN_CYCLES = 60;    // pipeline is 36 deep
    localparam int STALL_LIMIT  = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [TS_W-1:0] local_poll_rx, local_resp_tx, local_final_rx;
    logic [TS_W-1:0] remote_poll_tx, remote_resp_rx, remote_final_tx;
    logic done;
    logic signed [OUT_W-1:0] flight_time;
    logic zero_divisor;

    tof_scoreboard sb;
    int idle_cycles;
    int n_requests;
    int n_zero_div;
    int n_negative;

    ds_twr_time_of_flight u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .local_poll_rx  (local_poll_rx),
        .local_resp_tx  (local_resp_tx),
        .local_final_rx (local_final_rx),
        .remote_poll_tx (remote_poll_tx),
        .remote_resp_rx (remote_resp_rx),
        .remote_final_tx(remote_final_tx),
        .done           (done),
        .flight_time    (flight_time),
        .zero_divisor   (zero_divisor)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // a request is taken at any edge with start high and busy low
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_request('{local_poll_rx, local_resp_tx, local_final_rx,
                              remote_poll_tx, remote_resp_rx, remote_final_tx});
            n_requests++;
        end
        // results are valid for exactly the cycle that done is high
        if (rst_n && done)
        begin
            sb.check_result(flight_time, zero_divisor);
            if (zero_divisor)
                n_zero_div++;
            if (flight_time < 0)
                n_negative++;
        end
    end

    // watchdog: cycles with nothing accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("simulation failed");
            $finish;
        end
    end

    // present one request and hold it until accepted; optional random gap first
    task automatic send_request(exchange_t x, bit allow_gap);
        while (allow_gap && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        local_poll_rx   <= x.l_poll_rx;
        local_resp_tx   <= x.l_resp_tx;
        local_final_rx  <= x.l_final_rx;
        remote_poll_tx  <= x.r_poll_tx;
        remote_resp_rx  <= x.r_resp_rx;
        remote_final_tx <= x.r_final_tx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // build an exchange from local and remote base times and four intervals, wrapping mod 2^32
    function automatic exchange_t build_exchange(logic [31:0] lbase, logic [31:0] rbase,
                                                 logic [31:0] ra, logic [31:0] rb,
                                                 logic [31:0] da, logic [31:0] db);
        exchange_t x;
        x.r_poll_tx  = rbase;
        x.r_resp_rx  = rbase + ra;
        x.r_final_tx = rbase + ra + da;
        x.l_poll_rx  = lbase;
        x.l_resp_tx  = lbase + db;
        x.l_final_rx = lbase + db + rb;
        return x;
    endfunction

    // interval with a mix of zero, near-maximum, realistic small, mid and full-range values
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(9))
            0: return 32'(0);
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom_range(255);
            3, 4: return $urandom;
            default: return $urandom_range(32'h00FF_FFFF, 32'h0000_1000);
        endcase
    endfunction

    function automatic exchange_t random_exchange();
        exchange_t x;
        logic [31:0] tof, ra, db;
        if ($urandom_range(3) == 0)
        begin
            // fully random timestamps
            x.l_poll_rx = $urandom;  x.l_resp_tx = $urandom;  x.l_final_rx = $urandom;
            x.r_poll_tx = $urandom;  x.r_resp_rx = $urandom;  x.r_final_tx = $urandom;
            return x;
        end
        if ($urandom_range(1) == 0)
        begin
            // physically consistent exchange: Ra = 2 tof + Db, Rb = 2 tof + Da
            tof = $urandom_range(5000);
            ra  = pick_interval();
            db  = pick_interval();
            return build_exchange($urandom, $urandom, 2 * tof + db, 2 * tof + ra, ra, db);
        end
        return build_exchange($urandom, $urandom, pick_interval(), pick_interval(),
                              pick_interval(), pick_interval());
    endfunction

    initial
    begin
        exchange_t directed[$];
        exchange_t x;
        int quiet_len;

        sb = new();
        rst_n           <= 1'b0;
        start           <= 1'b0;
        local_poll_rx   <= '0;
        local_resp_tx   <= '0;
        local_final_rx  <= '0;
        remote_poll_tx  <= '0;
        remote_resp_rx  <= '0;
        remote_final_tx <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero divisor: all intervals zero, at zero and at the top of the range
        directed.push_back(build_exchange(0, 0, 0, 0, 0, 0));
        directed.push_back(build_exchange('1, '1, 0, 0, 0, 0));
        directed.push_back(build_exchange(32'h1234_5678, 32'h9ABC_DEF0, 0, 0, 0, 0));
        // every timestamp at its extremes
        directed.push_back('{'1, '1, '1, '1, '1, '1});
        directed.push_back('{'0, '1, '0, '1, '0, '1});
        directed.push_back('{'1, '0, '1, '0, '1, '0});
        // largest intervals, positive and negative extremes of the quotient
        directed.push_back(build_exchange(0, 0, '1, '1, 0, 0));
        directed.push_back(build_exchange(0, 0, 0, 0, '1, '1));
        directed.push_back(build_exchange(0, 0, '1, '1, '1, '1));
        directed.push_back(build_exchange(0, 0, '1, '1, 1, 1));
        directed.push_back(build_exchange(0, 0, 1, 1, '1, '1));
        directed.push_back(build_exchange(0, 0, '1, 0, 0, '1));
        // single nonzero interval, numerator zero but divisor nonzero
        directed.push_back(build_exchange(0, 0, 1, 0, 0, 0));
        directed.push_back(build_exchange(0, 0, 0, 0, 0, 1));
        // wrapped clocks: timestamps straddle the 2^32 rollover
        directed.push_back(build_exchange(32'hFFFF_FF00, 32'hFFFF_FFF0, 1000, 1200, 800, 600));
        directed.push_back(build_exchange(32'hFFFF_FFFF, 32'h8000_0000, 2000, 3000, 2500, 1500));
        // small truncation cases, both signs
        directed.push_back(build_exchange(100, 200, 3, 4, 2, 1));
        directed.push_back(build_exchange(100, 200, 1, 2, 3, 4));
        directed.push_back(build_exchange(5, 7, 7, 7, 7, 6));
        // typical physically consistent exchange with unequal reply times
        directed.push_back(build_exchange(32'h0100_0000, 32'h0200_0000,
                                          2 * 300 + 50000, 2 * 300 + 70000, 70000, 50000));

        foreach (directed[i])
            send_request(directed[i], 1'b0);
        start <= 1'b0;

        // hold off until every outstanding result has come back
        while (sb.pending.size() != 0)
            @(posedge clk);

        quiet_len = $urandom_range(400, 200);
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            x = random_exchange();
            // back-to-back stretch in the middle of the random part
            send_request(x, !(i >= 600 && i < 600 + quiet_len));
            if (i == 1200)
            begin
                start <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d exchanges, %0d results checked (%0d zero divisor, %0d negative)",
                 n_requests, sb.checked, n_zero_div, n_negative);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
